FILE: rtl/dbd_pkg.sv
// dbd_pkg: shared types, widths and register codes of the detection box decoder
// used by every file of the block; depends on nothing

package dbd_pkg;

  // fixed-point formats
  localparam int VALUE_BITS = 24;                 // tensor element, signed Q11.12
  localparam int FRAC_BITS  = 12;
  localparam int COORD_BITS = 23;                 // unsigned Q11.12 results
  localparam int CLASS_BITS = 8;
  localparam int INV_BITS   = 20;                 // inverse scale, unsigned Q8.12
  localparam int DIM_BITS   = 11;                 // image size in pixels
  localparam int THR_BITS   = 13;

  // arithmetic widths
  localparam int DIFF_W  = VALUE_BITS + 3;        // 2*cx - w - 2*pad
  localparam int PROD_XW = DIFF_W + INV_BITS + 1; // corner product
  localparam int PROD_WW = VALUE_BITS + INV_BITS + 1;
  localparam int SIZE_W  = PROD_WW + 1 - FRAC_BITS;

  localparam int MAX_CLASSES_DEF = 128;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd6;

  // one finished row: raw box and best class
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] cx;
    logic signed [VALUE_BITS-1:0] cy;
    logic signed [VALUE_BITS-1:0] w;
    logic signed [VALUE_BITS-1:0] h;
    logic [COORD_BITS-1:0]        conf;
    logic [CLASS_BITS-1:0]        cls;
  } row_t;

  // scaled products before rounding
  typedef struct packed {
    logic signed [PROD_XW-1:0] px;
    logic signed [PROD_XW-1:0] py;
    logic signed [PROD_WW-1:0] pw;
    logic signed [PROD_WW-1:0] ph;
    logic [COORD_BITS-1:0]     conf;
    logic [CLASS_BITS-1:0]     cls;
  } prod_t;

  // rounded and clamped corner, rounded size
  typedef struct packed {
    logic [COORD_BITS-1:0]    x;
    logic [COORD_BITS-1:0]    y;
    logic signed [SIZE_W-1:0] sw;
    logic signed [SIZE_W-1:0] sh;
    logic [COORD_BITS-1:0]    conf;
    logic [CLASS_BITS-1:0]    cls;
  } clip_t;

  // result box
  typedef struct packed {
    logic [COORD_BITS-1:0] conf;
    logic [CLASS_BITS-1:0] cls;
    logic [COORD_BITS-1:0] bh;
    logic [COORD_BITS-1:0] bw;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] left;
  } box_t;

endpackage

FILE: rtl/dbd_row.sv
// dbd_row: row position counter, box value capture and running best class
// depends on dbd_pkg

module dbd_row #(
  parameter int MAX_CLASSES = dbd_pkg::MAX_CLASSES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dbd_pkg::VALUE_BITS-1:0] in_value,
  input  logic [dbd_pkg::CLASS_BITS-1:0]        class_count,
  input  logic [dbd_pkg::THR_BITS-1:0]          score_threshold,
  output logic                                  row_valid,
  input  logic                                  row_ready,
  output dbd_pkg::row_t                         row
);

  localparam int POS_W    = $clog2(MAX_CLASSES + 4);
  localparam int LAST_MAX = MAX_CLASSES + 3;
  localparam int VB       = dbd_pkg::VALUE_BITS;

  logic [POS_W-1:0]                  pos_r;
  logic [POS_W-1:0]                  pos_nxt;
  logic [POS_W-1:0]                  last;
  logic signed [VB-1:0]              best_r;
  logic signed [VB-1:0]              best_sel;
  logic [dbd_pkg::CLASS_BITS-1:0]    idx_r;
  logic [dbd_pkg::CLASS_BITS-1:0]    idx_sel;
  logic signed [VB-1:0]              cx_r, cy_r, w_r, h_r;
  logic                              row_valid_r;
  dbd_pkg::row_t                     row_r;
  logic                              at_end;
  logic                              in_box;
  logic                              better;
  logic                              keep;
  logic                              acc;

  // last position of the row, class count limited to 1..MAX_CLASSES
  always_comb begin
    if (class_count == '0) begin
      last = POS_W'(4);
    end else if (32'(class_count) > MAX_CLASSES) begin
      last = POS_W'(LAST_MAX);
    end else begin
      last = POS_W'(class_count) + POS_W'(3);
    end
  end

  assign at_end   = (pos_r >= last);
  assign in_box   = (pos_r < POS_W'(4));
  assign better   = (in_value > best_r);
  assign best_sel = better ? in_value : best_r;
  assign idx_sel  = better ? dbd_pkg::CLASS_BITS'(pos_r - POS_W'(4)) : idx_r;
  assign keep     = (best_sel >= $signed(VB'(score_threshold)));

  // only a row end needs room downstream
  assign in_ready = !at_end || !row_valid_r || row_ready;
  assign acc      = in_valid && in_ready;
  assign pos_nxt  = at_end ? '0 : pos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      best_r      <= '0;
      idx_r       <= '1;
      cx_r        <= '0;
      cy_r        <= '0;
      w_r         <= '0;
      h_r         <= '0;
      row_valid_r <= 1'b0;
    end else begin
      if (row_ready) begin
        row_valid_r <= 1'b0;
      end
      if (acc) begin
        pos_r <= pos_nxt;
        if (in_box) begin
          unique case (pos_r[1:0])
            2'd0: cx_r <= in_value;
            2'd1: cy_r <= in_value;
            2'd2: w_r  <= in_value;
            default: h_r <= in_value;
          endcase
        end else if (at_end) begin
          best_r      <= '0;
          idx_r       <= '1;
          row_valid_r <= keep;
        end else begin
          best_r <= best_sel;
          idx_r  <= idx_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && at_end) begin
      row_r.cx   <= cx_r;
      row_r.cy   <= cy_r;
      row_r.w    <= w_r;
      row_r.h    <= h_r;
      row_r.conf <= best_sel[dbd_pkg::COORD_BITS-1:0];
      row_r.cls  <= idx_sel;
    end
  end

  assign row_valid = row_valid_r;
  assign row       = row_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(LAST_MAX))
    else $error("row position beyond last score");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && at_end) |=> (pos_r == '0 && idx_r == '1 && best_r == '0))
    else $error("row state not cleared after row end");

endmodule

FILE: rtl/dbd_scale.sv
// dbd_scale: centre to corner, padding removal and multiply by inverse scale
// depends on dbd_pkg

module dbd_scale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  row_valid,
  output logic                                  row_ready,
  input  dbd_pkg::row_t                         row,
  input  logic signed [dbd_pkg::VALUE_BITS-1:0] pad_left,
  input  logic signed [dbd_pkg::VALUE_BITS-1:0] pad_top,
  input  logic [dbd_pkg::INV_BITS-1:0]          inverse_scale,
  output logic                                  prod_valid,
  input  logic                                  prod_ready,
  output dbd_pkg::prod_t                        prod
);

  localparam int DW  = dbd_pkg::DIFF_W;
  localparam int PXW = dbd_pkg::PROD_XW;
  localparam int PWW = dbd_pkg::PROD_WW;
  localparam int VB  = dbd_pkg::VALUE_BITS;

  logic signed [VB-1:0]                 cx_s, cy_s, w_s, h_s;
  logic signed [DW-1:0]                 dx, dy;
  logic signed [dbd_pkg::INV_BITS:0]    inv_s;
  logic                                 prod_valid_r;
  dbd_pkg::prod_t                       prod_r;
  logic                                 adv;

  assign cx_s  = $signed(row.cx);
  assign cy_s  = $signed(row.cy);
  assign w_s   = $signed(row.w);
  assign h_s   = $signed(row.h);
  assign inv_s = $signed({1'b0, inverse_scale});

  // doubled corner in Q.13, exact
  assign dx = (DW'(cx_s) <<< 1) - DW'(w_s) - (DW'(pad_left) <<< 1);
  assign dy = (DW'(cy_s) <<< 1) - DW'(h_s) - (DW'(pad_top) <<< 1);

  assign row_ready = !prod_valid_r || prod_ready;
  assign adv       = row_valid && row_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (row_ready) begin
      prod_valid_r <= row_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r.px   <= PXW'(dx) * PXW'(inv_s);
      prod_r.py   <= PXW'(dy) * PXW'(inv_s);
      prod_r.pw   <= PWW'(w_s) * PWW'(inv_s);
      prod_r.ph   <= PWW'(h_s) * PWW'(inv_s);
      prod_r.conf <= row.conf;
      prod_r.cls  <= row.cls;
    end
  end

  assign prod_valid = prod_valid_r;
  assign prod       = prod_r;

endmodule

FILE: rtl/dbd_clip.sv
// dbd_clip: rounding, clamp to image, size limit and result register
// depends on dbd_pkg

module dbd_clip (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           prod_valid,
  output logic                           prod_ready,
  input  dbd_pkg::prod_t                 prod,
  input  logic [dbd_pkg::DIM_BITS-1:0]   image_width,
  input  logic [dbd_pkg::DIM_BITS-1:0]   image_height,
  output logic                           box_valid,
  input  logic                           box_ready,
  output dbd_pkg::box_t                  box
);

  localparam int PXW = dbd_pkg::PROD_XW;
  localparam int PWW = dbd_pkg::PROD_WW;
  localparam int SW  = dbd_pkg::SIZE_W;
  localparam int CB  = dbd_pkg::COORD_BITS;
  localparam int FB  = dbd_pkg::FRAC_BITS;

  logic [CB-1:0]         wmax, hmax;
  logic signed [PXW:0]   xsum, ysum, xr, yr, wmax_s, hmax_s;
  logic signed [PWW:0]   wsum, hsum, swr, shr;
  logic [CB-1:0]         x_c, y_c;
  logic                  s3_valid_r;
  dbd_pkg::clip_t        s3_r;
  logic                  out_ready;
  logic [CB-1:0]         lim_w, lim_h;
  logic                  w_cut, h_cut, emit;
  logic                  box_valid_r;
  dbd_pkg::box_t         box_r;

  assign wmax   = {image_width, FB'(0)};
  assign hmax   = {image_height, FB'(0)};
  assign wmax_s = $signed((PXW+1)'(wmax));
  assign hmax_s = $signed((PXW+1)'(hmax));

  // corner: round half up out of Q.25, size: out of Q.24
  assign xsum = $signed((PXW+1)'(prod.px)) + $signed((PXW+1)'(1 << FB));
  assign ysum = $signed((PXW+1)'(prod.py)) + $signed((PXW+1)'(1 << FB));
  assign xr   = xsum >>> (FB + 1);
  assign yr   = ysum >>> (FB + 1);
  assign wsum = $signed((PWW+1)'(prod.pw)) + $signed((PWW+1)'(1 << (FB - 1)));
  assign hsum = $signed((PWW+1)'(prod.ph)) + $signed((PWW+1)'(1 << (FB - 1)));
  assign swr  = wsum >>> FB;
  assign shr  = hsum >>> FB;

  always_comb begin
    priority if (xr < 0) begin
      x_c = '0;
    end else if (xr > wmax_s) begin
      x_c = wmax;
    end else begin
      x_c = xr[CB-1:0];
    end
    priority if (yr < 0) begin
      y_c = '0;
    end else if (yr > hmax_s) begin
      y_c = hmax;
    end else begin
      y_c = yr[CB-1:0];
    end
  end

  assign out_ready  = !box_valid_r || box_ready;
  assign prod_ready = !s3_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (prod_ready) begin
      s3_valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      s3_r.x    <= x_c;
      s3_r.y    <= y_c;
      s3_r.sw   <= swr[SW-1:0];
      s3_r.sh   <= shr[SW-1:0];
      s3_r.conf <= prod.conf;
      s3_r.cls  <= prod.cls;
    end
  end

  // room left to the image edge, never negative after the clamp
  assign lim_w = wmax - s3_r.x;
  assign lim_h = hmax - s3_r.y;
  assign w_cut = (s3_r.sw > $signed(SW'(lim_w)));
  assign h_cut = (s3_r.sh > $signed(SW'(lim_h)));
  assign emit  = (s3_r.sw > 0) && (lim_w != '0) && (s3_r.sh > 0) && (lim_h != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_valid_r <= 1'b0;
    end else if (out_ready) begin
      box_valid_r <= s3_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid_r) begin
      box_r.left <= s3_r.x;
      box_r.top  <= s3_r.y;
      box_r.bw   <= w_cut ? lim_w : s3_r.sw[CB-1:0];
      box_r.bh   <= h_cut ? lim_h : s3_r.sh[CB-1:0];
      box_r.cls  <= s3_r.cls;
      box_r.conf <= s3_r.conf;
    end
  end

  assign box_valid = box_valid_r;
  assign box       = box_r;

  a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(box_valid_r) |-> $past(s3_valid_r))
    else $error("result appeared without a clamped row behind it");

endmodule

FILE: rtl/detection_box_decoder.sv
// detection_box_decoder: top level, configuration registers and result packing
// depends on dbd_pkg, dbd_row, dbd_scale and dbd_clip
//
// usage
//   in_*  : one tensor element per request, rows of cx, cy, w, h and then
//           class_count scores, signed Q11.12 in in_tdata[23:0]
//   out_* : a box per kept nonempty row, Q11.12 corner/size, class, score
//   cfg_* : register writes, index as listed in the package, always ready;
//           write only while no row is in flight
//   throughput: one element per cycle; in_tready drops only on the last
//   score of a row while the row register still holds a row that the
//   stage behind it cannot take
//   path: the row register loads at the edge that takes the last score
//   of its row; the box then passes the multiplier register, the clamp
//   register and the result register
//   the stages advance independently, so a stalled receiver holds the box
//   in the result register while further elements are still taken; back
//   pressure reaches in_tready only when every stage holds a row
//   reset (rst_n low, synchronous) empties all stages, sets the row counter
//   to the start of a row and loads the register defaults

module detection_box_decoder #(
  parameter int MAX_CLASSES = dbd_pkg::MAX_CLASSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tensor elements
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,   // value[23:0]
  // boxes
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // left[22:0], top[45:23], box_width[68:46], box_height[91:69],
  // class_id[99:92], confidence[122:100], zero[127:123]
  output logic [127:0]                       out_tdata,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int VB = dbd_pkg::VALUE_BITS;

  // configuration registers
  logic [dbd_pkg::CLASS_BITS-1:0]  class_count_r;
  logic [dbd_pkg::THR_BITS-1:0]    score_threshold_r;
  logic signed [VB-1:0]            pad_left_r;
  logic signed [VB-1:0]            pad_top_r;
  logic [dbd_pkg::INV_BITS-1:0]    inverse_scale_r;
  logic [dbd_pkg::DIM_BITS-1:0]    image_width_r;
  logic [dbd_pkg::DIM_BITS-1:0]    image_height_r;

  // stage links
  logic            row_valid, row_ready;
  dbd_pkg::row_t   row;
  logic            prod_valid, prod_ready;
  dbd_pkg::prod_t  prod;
  dbd_pkg::box_t   box;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r     <= dbd_pkg::CLASS_BITS'(80);
      score_threshold_r <= dbd_pkg::THR_BITS'(2048);
      pad_left_r        <= '0;
      pad_top_r         <= '0;
      inverse_scale_r   <= dbd_pkg::INV_BITS'(4096);
      image_width_r     <= dbd_pkg::DIM_BITS'(640);
      image_height_r    <= dbd_pkg::DIM_BITS'(640);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dbd_pkg::REG_CLASS_COUNT:     class_count_r     <= cfg_data[dbd_pkg::CLASS_BITS-1:0];
        dbd_pkg::REG_SCORE_THRESHOLD: score_threshold_r <= cfg_data[dbd_pkg::THR_BITS-1:0];
        dbd_pkg::REG_PAD_LEFT:        pad_left_r        <= $signed(cfg_data[VB-1:0]);
        dbd_pkg::REG_PAD_TOP:         pad_top_r         <= $signed(cfg_data[VB-1:0]);
        dbd_pkg::REG_INVERSE_SCALE:   inverse_scale_r   <= cfg_data[dbd_pkg::INV_BITS-1:0];
        dbd_pkg::REG_IMAGE_WIDTH:     image_width_r     <= cfg_data[dbd_pkg::DIM_BITS-1:0];
        dbd_pkg::REG_IMAGE_HEIGHT:    image_height_r    <= cfg_data[dbd_pkg::DIM_BITS-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // row counter and running best score
  dbd_row #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_row (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_value        ($signed(in_tdata[VB-1:0])),
    .class_count     (class_count_r),
    .score_threshold (score_threshold_r),
    .row_valid       (row_valid),
    .row_ready       (row_ready),
    .row             (row)
  );

  // corner and size products
  dbd_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .row_valid     (row_valid),
    .row_ready     (row_ready),
    .row           (row),
    .pad_left      (pad_left_r),
    .pad_top       (pad_top_r),
    .inverse_scale (inverse_scale_r),
    .prod_valid    (prod_valid),
    .prod_ready    (prod_ready),
    .prod          (prod)
  );

  // rounding, clamp and result register
  dbd_clip u_clip (
    .clk          (clk),
    .rst_n        (rst_n),
    .prod_valid   (prod_valid),
    .prod_ready   (prod_ready),
    .prod         (prod),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .box_valid    (out_tvalid),
    .box_ready    (out_tready),
    .box          (box)
  );

  assign out_tdata = {5'b0, box.conf, box.cls, box.bh, box.bw, box.top, box.left};

  a_box_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[68:46] != '0 && out_tdata[91:69] != '0))
    else $error("box with zero size delivered");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (row_valid && !row_ready))
    else $error("input held off with room in the row stage");

endmodule
